// File: rtl/calibrated_spectrum_rebin_accumulate_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calibrated spectrum rebinning accumulator
// Shared property wrappers; every user has clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef CALIBRATED_SPECTRUM_REBIN_ACCUMULATE_DEFINES_SVH
`define CALIBRATED_SPECTRUM_REBIN_ACCUMULATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csra_pkg.sv
// ----------------------------------------------------------------------------
// csra_pkg
// Types and constants shared by the rebinning accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csra_pkg;

  localparam int BIN_W       = 16;  // bin index of a command, up to 65536 bins
  localparam int BIN_SW      = 18;  // signed bin number from an energy
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C3       = 3'd5;

  localparam logic [63:0] Q_ONE     = 64'h0001_0000_0000_0000;
  localparam logic [63:0] Q_HALF    = 64'h0000_8000_0000_0000;
  localparam logic [63:0] Q_QUARTER = 64'h0000_4000_0000_0000;
  localparam logic [63:0] HALF_MASK = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] U64_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  // One unit of work for the bin store: a saturating add or a read.
  typedef struct packed {
    logic             is_read;
    logic [BIN_W-1:0] bin;
    logic [63:0]      amount;
  } bin_cmd_t;

endpackage

`default_nettype wire

// File: rtl/csra_queue.sv
// ----------------------------------------------------------------------------
// csra_queue
// Short command queue between the arithmetic front end and the bin store.
// ----------------------------------------------------------------------------
`default_nettype none

module csra_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire csra_pkg::bin_cmd_t push_cmd,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output csra_pkg::bin_cmd_t      pop_cmd
);
  import csra_pkg::*;

  bin_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/csra_front.sv
// ----------------------------------------------------------------------------
// csra_front
// Takes items, evaluates the calibration, finds bins and shares, and issues
// bin store commands.
// ----------------------------------------------------------------------------
`default_nettype none

module csra_front #(
  parameter int SUM_BINS       = 16384,
  parameter int INPUT_CHANNELS = 16384
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [csra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            opcode,
  input  wire logic [13:0]                     channel_index,
  input  wire logic [31:0]                     channel_count,
  input  wire logic [13:0]                     bin_address,
  output logic                                 cmd_valid,
  input  wire logic                            cmd_ready,
  output csra_pkg::bin_cmd_t                   cmd
);
  import csra_pkg::*;

  typedef enum logic [12:0] {
    F_IDLE  = 13'b0000000000001,
    F_MLOAD = 13'b0000000000010,
    F_MUL   = 13'b0000000000100,
    F_MFIN  = 13'b0000000001000,
    F_ADD   = 13'b0000000010000,
    F_CLASS = 13'b0000000100000,
    F_JOB   = 13'b0000001000000,
    F_SMUL  = 13'b0000010000000,
    F_DSET  = 13'b0000100000000,
    F_DIV   = 13'b0001000000000,
    F_SHARE = 13'b0010000000000,
    F_MID   = 13'b0100000000000,
    F_PUSH  = 13'b1000000000000
  } front_state_t;

  localparam logic [1:0] J_LO   = 2'd0;
  localparam logic [1:0] J_HI   = 2'd1;
  localparam logic [1:0] J_MID  = 2'd2;
  localparam logic [1:0] J_DONE = 2'd3;

  localparam logic signed [BIN_SW-1:0] SB_S   = $signed(BIN_SW'(SUM_BINS));
  localparam logic signed [BIN_SW-1:0] BIN_BIAS = 18'sd65536;

  front_state_t state;

  logic [63:0] shift_offset, shift_gain, cal_c0, cal_c1, cal_c2, cal_c3;

  logic [13:0]  ch;
  logic [31:0]  cnt;
  logic         edge_hi;
  logic [1:0]   k;
  logic [1:0]   pidx;
  logic [63:0]  ma, mb;
  logic         neg;
  logic [127:0] prod;
  logic [63:0]  mres;
  logic [63:0]  s_reg, e_reg, elo, ehi;
  logic signed [BIN_SW-1:0] lb, hb, cur;
  logic [1:0]   job;
  logic [63:0]  den;
  logic [47:0]  num;
  logic [63:0]  rem, quo, lo_bits;
  logic [5:0]   dcnt;
  logic [63:0]  mid_amt;
  bin_cmd_t     cmd_reg;

  // Operands of the current calibration step.
  logic [63:0]  centre, edge_val, op_a, op_b, addend;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_ext;
  logic [63:0]  qv, qinc, mfin;
  logic         over, frac, over_n;
  logic [63:0]  sum, sat_sum;
  logic signed [BIN_SW-1:0] lb_c, hb_c, first_bin, last_bin;
  logic [63:0]  elo_u, ehi_u;
  logic [31:0]  snum_part;
  logic [63:0]  spp;
  logic [64:0]  rem_sh;
  logic         rem_top;
  logic         take;

  always_comb begin
    centre   = {2'b00, ch, 48'h0};
    edge_val = edge_hi ? (centre + Q_HALF) : (centre - Q_HALF);
    case (k)
      2'd0: begin
        op_a = shift_gain; op_b = edge_val; addend = shift_offset;
      end
      2'd1: begin
        op_a = cal_c3; op_b = s_reg; addend = cal_c2;
      end
      2'd2: begin
        op_a = e_reg; op_b = s_reg; addend = cal_c1;
      end
      default: begin
        op_a = e_reg; op_b = s_reg; addend = cal_c0;
      end
    endcase
  end

  always_comb begin
    a_part = pidx[1] ? ma[63:32] : ma[31:0];
    b_part = pidx[0] ? mb[63:32] : mb[31:0];
    pp     = a_part * b_part;
    case (pidx)
      2'd0:    pp_ext = {64'h0, pp};
      2'd3:    pp_ext = {pp, 64'h0};
      default: pp_ext = {32'h0, pp, 32'h0};
    endcase
  end

  // Scale the magnitude product back to Q15.48, floor for negative results,
  // and saturate.
  always_comb begin
    over   = |prod[127:112];
    qv     = prod[111:48];
    frac   = |prod[47:0];
    qinc   = qv + {63'h0, frac};
    over_n = over || (frac && (qv == U64_MAX));
    if (!neg) begin
      mfin = (over || qv[63]) ? S64_MAX : qv;
    end else if (over_n || (qinc[63] && (|qinc[62:0]))) begin
      mfin = S64_MIN;
    end else begin
      mfin = 64'h0 - qinc;
    end
  end

  always_comb begin
    sum = addend + mres;
    if ((addend[63] == mres[63]) && (sum[63] != addend[63])) begin
      sat_sum = addend[63] ? S64_MIN : S64_MAX;
    end else begin
      sat_sum = sum;
    end
  end

  // floor(2*E + 0.5): the biased top bits give floor(2*E), bit 46 the rounding.
  always_comb begin
    elo_u = elo ^ S64_MIN;
    ehi_u = ehi ^ S64_MIN;
    lb_c  = $signed({1'b0, elo_u[63:47]}) - BIN_BIAS + $signed({17'h0, elo[46]});
    hb_c  = $signed({1'b0, ehi_u[63:47]}) - BIN_BIAS + $signed({17'h0, ehi[46]});
    first_bin = (lb < 0) ? '0 : (lb + 18'sd1);
    last_bin  = (hb > SB_S) ? SB_S : hb;
  end

  always_comb begin
    snum_part = pidx[0] ? {16'h0, num[47:32]} : num[31:0];
    spp       = cnt * snum_part;
    rem_top   = rem[63];
    rem_sh    = {rem, lo_bits[63]};
    take      = rem_top || (rem_sh[63:0] >= den);
  end

  assign in_ready  = (state == F_IDLE);
  assign cmd_valid = (state == F_PUSH) || ((state == F_MID) && (cur < last_bin));
  assign cmd       = (state == F_MID) ? '{is_read: OP_ADD, bin: cur[BIN_W-1:0],
                                          amount: mid_amt} : cmd_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_offset <= '0;
      shift_gain   <= Q_ONE;
      cal_c0       <= '0;
      cal_c1       <= Q_ONE;
      cal_c2       <= '0;
      cal_c3       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHIFT_OFFSET: shift_offset <= cfg_data;
        REG_SHIFT_GAIN:   shift_gain   <= cfg_data;
        REG_CAL_C0:       cal_c0       <= cfg_data;
        REG_CAL_C1:       cal_c1       <= cfg_data;
        REG_CAL_C2:       cal_c2       <= cfg_data;
        REG_CAL_C3:       cal_c3       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      job   <= J_DONE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            ch  <= channel_index;
            cnt <= channel_count;
            if (opcode == OP_READ) begin
              cmd_reg <= '{is_read: OP_READ, bin: BIN_W'(bin_address), amount: '0};
              job     <= J_DONE;
              state   <= F_PUSH;
            end else if ({3'b000, channel_index} >= 17'(INPUT_CHANNELS)) begin
              state <= F_IDLE;
            end else begin
              edge_hi <= 1'b0;
              k       <= 2'd0;
              state   <= F_MLOAD;
            end
          end
        end
        F_MLOAD: begin
          ma    <= op_a[63] ? (64'h0 - op_a) : op_a;
          mb    <= op_b[63] ? (64'h0 - op_b) : op_b;
          neg   <= op_a[63] != op_b[63];
          prod  <= '0;
          pidx  <= 2'd0;
          state <= F_MUL;
        end
        F_MUL: begin
          prod <= prod + pp_ext;
          pidx <= pidx + 1'b1;
          if (pidx == 2'd3) begin
            state <= F_MFIN;
          end
        end
        F_MFIN: begin
          mres  <= mfin;
          state <= F_ADD;
        end
        F_ADD: begin
          if (k == 2'd0) begin
            s_reg <= sat_sum;
          end else begin
            e_reg <= sat_sum;
          end
          if (k != 2'd3) begin
            k     <= k + 1'b1;
            state <= F_MLOAD;
          end else if (!edge_hi) begin
            elo     <= sat_sum;
            edge_hi <= 1'b1;
            k       <= 2'd0;
            state   <= F_MLOAD;
          end else begin
            ehi   <= sat_sum;
            state <= F_CLASS;
          end
        end
        F_CLASS: begin
          lb  <= lb_c;
          hb  <= hb_c;
          den <= ehi - elo;
          if (!((lb_c < SB_S) && (hb_c > 0))) begin
            state <= F_IDLE;
          end else if (lb_c == hb_c) begin
            cmd_reg <= '{is_read: OP_ADD, bin: lb_c[BIN_W-1:0],
                         amount: {16'h0, cnt, 16'h0}};
            job     <= J_DONE;
            state   <= F_PUSH;
          end else if (lb_c > hb_c) begin
            state <= F_IDLE;
          end else begin
            job   <= J_LO;
            state <= F_JOB;
          end
        end
        F_JOB: begin
          case (job)
            J_LO: begin
              if (lb >= 0) begin
                num   <= 48'(Q_HALF - ((elo + Q_QUARTER) & HALF_MASK));
                pidx  <= 2'd0;
                state <= F_SMUL;
              end else begin
                job <= J_HI;
              end
            end
            J_HI: begin
              if (hb < SB_S) begin
                num   <= 48'((ehi + Q_QUARTER) & HALF_MASK);
                pidx  <= 2'd0;
                state <= F_SMUL;
              end else begin
                job <= J_MID;
              end
            end
            J_MID: begin
              num   <= 48'(Q_HALF);
              pidx  <= 2'd0;
              state <= F_SMUL;
            end
            default: state <= F_IDLE;
          endcase
        end
        F_SMUL: begin
          if (pidx == 2'd0) begin
            prod <= {64'h0, spp};
            pidx <= 2'd1;
          end else begin
            prod  <= prod + {32'h0, spp, 32'h0};
            state <= F_DSET;
          end
        end
        F_DSET: begin
          if ({32'h0, prod[79:48]} >= den) begin
            quo   <= U64_MAX;
            state <= F_SHARE;
          end else begin
            rem     <= {32'h0, prod[79:48]};
            lo_bits <= {prod[47:0], 16'h0};
            quo     <= '0;
            dcnt    <= '0;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          lo_bits <= {lo_bits[62:0], 1'b0};
          if (take) begin
            rem <= rem_sh[63:0] - den;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) begin
            state <= F_SHARE;
          end
        end
        F_SHARE: begin
          case (job)
            J_LO: begin
              cmd_reg <= '{is_read: OP_ADD, bin: lb[BIN_W-1:0], amount: quo};
              job     <= J_HI;
              state   <= F_PUSH;
            end
            J_HI: begin
              cmd_reg <= '{is_read: OP_ADD, bin: hb[BIN_W-1:0], amount: quo};
              job     <= J_MID;
              state   <= F_PUSH;
            end
            default: begin
              mid_amt <= quo;
              cur     <= first_bin;
              state   <= F_MID;
            end
          endcase
        end
        F_MID: begin
          if (!(cur < last_bin)) begin
            state <= F_IDLE;
          end else if (cmd_ready) begin
            cur <= cur + 18'sd1;
          end
        end
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_JOB;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/csra_back.sv
// ----------------------------------------------------------------------------
// csra_back
// Bin store: clearing pass, saturating read-modify-write and read results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calibrated_spectrum_rebin_accumulate_defines.svh"

module csra_back #(
  parameter int SUM_BINS = 16384
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire csra_pkg::bin_cmd_t q_cmd,
  output logic                    clear_done,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [13:0]             bin_number,
  output logic [63:0]             bin_value
);
  import csra_pkg::*;

  localparam int AW = $clog2(SUM_BINS);

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_RD    = 4'b0100,
    B_WR    = 4'b1000
  } back_state_t;

  back_state_t  state;
  logic [63:0]  mem [SUM_BINS];
  logic [63:0]  rdata;
  logic [AW-1:0] clr_idx;
  bin_cmd_t     cur;
  logic         cur_in_range;
  logic         mem_we;
  logic [AW-1:0] mem_wa;
  logic [63:0]  mem_wd;
  logic [63:0]  add_sum;
  logic         add_carry;
  logic         res_load;

  assign clear_done = (state != B_CLEAR);
  assign q_pop      = (state == B_IDLE) && q_valid;
  // A read result enters the output register once that register is free.
  assign res_load   = (state == B_WR) && cur.is_read && (!out_valid || out_ready);

  always_comb begin
    {add_carry, add_sum} = {1'b0, rdata} + {1'b0, cur.amount};
    mem_we = (state == B_CLEAR) || ((state == B_WR) && !cur.is_read);
    mem_wa = (state == B_CLEAR) ? clr_idx : cur.bin[AW-1:0];
    mem_wd = (state == B_CLEAR) ? 64'h0 : (add_carry ? U64_MAX : add_sum);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rdata <= mem[q_cmd.bin[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(SUM_BINS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            cur          <= q_cmd;
            cur_in_range <= {1'b0, q_cmd.bin} < (BIN_W+1)'(SUM_BINS);
            state        <= B_WR;
          end
        end
        B_WR: begin
          if (!cur.is_read) begin
            state <= B_IDLE;
          end else if (res_load) begin
            bin_number <= cur.bin[13:0];
            bin_value  <= cur_in_range ? rdata : 64'h0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `CSRA_ASSERT_NOW(a_no_pop_in_clear, state == B_CLEAR, !q_pop, "command taken during clearing pass")
  `CSRA_ASSERT_NEXT(a_pop_then_write, q_pop, state == B_WR, "popped command not executed next")
  `CSRA_ASSERT_NEXT(a_add_single_cycle, (state == B_WR) && !cur.is_read, state == B_IDLE, "add did not complete")

endmodule

`default_nettype wire

// File: rtl/calibrated_spectrum_rebin_accumulate.sv
// ----------------------------------------------------------------------------
// calibrated_spectrum_rebin_accumulate
// Rebins calibrated source channels into a half-unit sum histogram.
// ----------------------------------------------------------------------------
// Usage. The input channel carries an opcode with its fields: an add spreads
// channel_count over the sum bins covered by the calibrated edges of
// channel_index, a read returns one bin on the output channel. Both channels
// use valid/ready; one transfer moves one item. Registers are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the block
// is idle; the block does not enforce it. An add does two cubic evaluations
// (each 64x64 product from four partial products on one 32x32 multiplier), up
// to three shares from the bit-serial divider, and one bin per cycle, while the
// queue accepts, for bins strictly inside the range. The store reads a popped
// command's bin and an add writes back the saturated sum, so it takes the next
// command only after the last is done. After reset the store is cleared one bin
// a cycle through all SUM_BINS bins; in_ready stays low meanwhile. A stalled
// receiver holds the result in the output register; the back end then waits
// and the command queue backs up into the front end.
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_spectrum_rebin_accumulate #(
  parameter int SUM_BINS       = 16384,
  parameter int INPUT_CHANNELS = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [13:0] channel_index,
  input  wire logic [31:0] channel_count,
  input  wire logic [13:0] bin_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      bin_number,
  output logic [63:0]      bin_value
);
  import csra_pkg::*;

  logic     front_ready;
  logic     clear_done;
  logic     cmd_valid, cmd_ready;
  bin_cmd_t cmd;
  logic     q_valid, q_pop;
  bin_cmd_t q_cmd;

  assign in_ready = front_ready && clear_done;

  csra_front #(
    .SUM_BINS       (SUM_BINS),
    .INPUT_CHANNELS (INPUT_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid && clear_done),
    .in_ready      (front_ready),
    .opcode        (opcode),
    .channel_index (channel_index),
    .channel_count (channel_count),
    .bin_address   (bin_address),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  csra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_cmd   (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_cmd    (q_cmd)
  );

  csra_back #(
    .SUM_BINS (SUM_BINS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .clear_done (clear_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bin_number (bin_number),
    .bin_value  (bin_value)
  );

endmodule

`default_nettype wire
